// File: rtl/core/mbet_pkg.sv
package mbet_pkg;

    localparam int FRAC_BITS = 24;
    localparam int PROD_W    = 64;
    localparam int SQ_W      = PROD_W - FRAC_BITS;
    localparam int WIDE_W    = SQ_W + 2;
    localparam int CNT_W     = 16;
    localparam int PIX_W     = 10;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_ORIGIN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_ORIGIN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_REAL   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_IMAG   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE_RSQ  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITER    = 3'd5;

    localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd33554432;
    localparam logic signed [31:0] RST_IMAG_ORIGIN = -32'sd25165824;
    localparam logic [24:0]        RST_STEP        = 25'd49152;
    localparam logic [30:0]        RST_ESCAPE_RSQ  = 31'd1677721600;
    localparam logic [CNT_W-1:0]   RST_MAX_ITER    = 16'd256;

    typedef struct packed {
        logic signed [31:0] real_origin;
        logic signed [31:0] imag_origin;
        logic [24:0]        step_real;
        logic [24:0]        step_imag;
        logic [30:0]        escape_radius_sq;
        logic [CNT_W-1:0]   max_iterations;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic [PIX_W-1:0] column;
        logic [PIX_W-1:0] row;
        logic [CNT_W-1:0] count;
        logic             in_set;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRE,
        S_CIM,
        S_CWAIT,
        S_XX,
        S_YY,
        S_XY,
        S_CHK,
        S_DONE
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (!v[WIDE_W-1] && (|v[WIDE_W-2:31])) begin
            r = 32'sh7FFF_FFFF;
        end else if (v[WIDE_W-1] && !(&v[WIDE_W-2:31])) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/mbet_mul.sv
module mbet_mul (
    input  logic                             i_clk,
    input  mbet_pkg::t_mul_req               i_req,
    output logic signed [mbet_pkg::PROD_W-1:0] o_prod
);
    import mbet_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/mbet_seq.sv
module mbet_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mbet_pkg::PIX_W-1:0]         i_column,
    input  logic [mbet_pkg::PIX_W-1:0]         i_row,
    input  mbet_pkg::t_cfg                     i_cfg,
    output logic                               o_ready,
    output logic                               o_done,
    input  logic                               i_res_ready,
    output mbet_pkg::t_result                  o_res,
    output mbet_pkg::t_mul_req                 o_mul_req,
    input  logic signed [mbet_pkg::PROD_W-1:0] i_mul_prod
);
    import mbet_pkg::*;

    t_state r_state, n_state;

    logic [PIX_W-1:0]         r_col, r_row;
    logic [CNT_W-1:0]         r_count;
    logic signed [31:0]       r_cre, r_cim, r_x, r_y;
    logic signed [SQ_W-1:0]   r_x2, r_y2;

    logic signed [SQ_W-1:0]   prod_fx;
    logic signed [WIDE_W-1:0] c_sum;
    logic signed [SQ_W:0]     mag;
    logic                     escape;
    logic signed [WIDE_W-1:0] x_next, y_next;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     limit_hit;

    assign prod_fx = i_mul_prod[PROD_W-1:FRAC_BITS];
    assign c_sum = (r_state == S_CIM)
        ? WIDE_W'(i_cfg.real_origin) + $signed(i_mul_prod[WIDE_W-1:0])
        : WIDE_W'(i_cfg.imag_origin) + $signed(i_mul_prod[WIDE_W-1:0]);
    assign mag    = (SQ_W+1)'(r_x2) + (SQ_W+1)'(r_y2);
    assign escape = mag > $signed({{(SQ_W-30){1'b0}}, i_cfg.escape_radius_sq});
    assign x_next = WIDE_W'(r_x2) - WIDE_W'(r_y2) + WIDE_W'(r_cre);
    assign y_next = WIDE_W'($signed({prod_fx, 1'b0})) + WIDE_W'(r_cim);
    assign cnt_inc   = r_count + 1'b1;
    assign limit_hit = (cnt_inc == i_cfg.max_iterations);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_CRE;
            S_CRE:   n_state = S_CIM;
            S_CIM:   n_state = S_CWAIT;
            S_CWAIT: n_state = (i_cfg.max_iterations == '0) ? S_DONE : S_XX;
            S_XX:    n_state = S_YY;
            S_YY:    n_state = S_XY;
            S_XY:    n_state = S_CHK;
            S_CHK:   n_state = (escape || limit_hit) ? S_DONE : S_XX;
            S_DONE:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_done    = 1'b0;
        o_mul_req = '0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_CRE: begin
                o_mul_req.a = 32'(r_col);
                o_mul_req.b = 32'(i_cfg.step_real);
            end
            S_CIM: begin
                o_mul_req.a = 32'(r_row);
                o_mul_req.b = 32'(i_cfg.step_imag);
            end
            S_XX: begin
                o_mul_req.a = r_x;
                o_mul_req.b = r_x;
            end
            S_YY: begin
                o_mul_req.a = r_y;
                o_mul_req.b = r_y;
            end
            S_XY: begin
                o_mul_req.a = r_x;
                o_mul_req.b = r_y;
            end
            S_DONE: o_done = 1'b1;
            default: o_mul_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_col   <= i_column;
                r_row   <= i_row;
                r_count <= '0;
            end
            S_CIM: begin
                r_cre <= sat32(c_sum);
                r_x   <= sat32(c_sum);
            end
            S_CWAIT: begin
                r_cim <= sat32(c_sum);
                r_y   <= sat32(c_sum);
            end
            S_YY: r_x2 <= prod_fx;
            S_XY: r_y2 <= prod_fx;
            S_CHK: begin
                if (!escape) begin
                    r_count <= cnt_inc;
                    r_x     <= sat32(x_next);
                    r_y     <= sat32(y_next);
                end
            end
            default: ;
        endcase
    end

    assign o_res.column = r_col;
    assign o_res.row    = r_row;
    assign o_res.count  = r_count;
    assign o_res.in_set = (r_count == i_cfg.max_iterations);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_CRE) |-> (r_count <= i_cfg.max_iterations))
        else $error("iteration count above limit");

    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_CRE))
        else $error("accepted pixel did not start");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && !escape) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("count did not advance on a passed test");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_res_ready) |=> (r_state == S_DONE && $stable(r_count)))
        else $error("result dropped while output busy");

endmodule

// File: rtl/core/mandelbrot_escape_time_core.sv
// Escape-time core: one pixel in, one result out.
// Input stream s_axis: tdata carries the pixel column and row. An item is taken
// only while the core is idle (s_axis_tready high).
// Output stream m_axis: tdata carries column, row, iteration count and the
// in-set flag, held in an output register until the receiver takes it.
// Config port: i_cfg_wr_en writes i_cfg_wr_data into register i_cfg_addr
// (0 real origin, 1 imag origin, 2 real step, 3 imag step, 4 escape radius
// squared, 5 iteration limit). Write only while no pixel is in flight.
// Sequence: one 32x32 multiplier is shared for every product. Setup of the point
// runs through states CRE, CIM and CWAIT, each tested round through XX, YY and
// XY (three products) and CHK (the check), and DONE then hands the result to
// the output register; R rounds are tested, R from 0 up to the iteration
// limit. The next pixel is taken only in the idle state that follows, so a
// pixel is never accepted while another is still in the core.
// Reset clears the state machine and output valid and loads default config.
// A stalled receiver holds the finished result in the core and the output
// register; the next pixel is not accepted until the core's result moves on.
module mandelbrot_escape_time_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,  // column[9:0], row[19:10]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [39:0]                         m_axis_tdata,  // out_column[9:0], out_row[19:10],
                                                               // iteration_count[35:20], in_set[36]
    input  logic                                i_cfg_wr_en,
    input  logic [mbet_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mbet_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);
    import mbet_pkg::*;

    t_cfg                     r_cfg;
    t_mul_req                 mul_req;
    logic signed [PROD_W-1:0] mul_prod;
    t_result                  res;
    logic                     seq_ready, seq_done, res_ready;
    logic                     r_out_valid;
    t_result                  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_origin      <= RST_REAL_ORIGIN;
            r_cfg.imag_origin      <= RST_IMAG_ORIGIN;
            r_cfg.step_real        <= RST_STEP;
            r_cfg.step_imag        <= RST_STEP;
            r_cfg.escape_radius_sq <= RST_ESCAPE_RSQ;
            r_cfg.max_iterations   <= RST_MAX_ITER;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_REAL_ORIGIN: r_cfg.real_origin      <= $signed(i_cfg_wr_data);
                CFG_IMAG_ORIGIN: r_cfg.imag_origin      <= $signed(i_cfg_wr_data);
                CFG_STEP_REAL:   r_cfg.step_real        <= i_cfg_wr_data[24:0];
                CFG_STEP_IMAG:   r_cfg.step_imag        <= i_cfg_wr_data[24:0];
                CFG_ESCAPE_RSQ:  r_cfg.escape_radius_sq <= i_cfg_wr_data[30:0];
                CFG_MAX_ITER:    r_cfg.max_iterations   <= i_cfg_wr_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    mbet_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    mbet_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid),
        .i_column    (s_axis_tdata[PIX_W-1:0]),
        .i_row       (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_cfg       (r_cfg),
        .o_ready     (seq_ready),
        .o_done      (seq_done),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mul_req   (mul_req),
        .i_mul_prod  (mul_prod)
    );

    assign s_axis_tready = seq_ready;
    assign res_ready     = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= seq_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && seq_done) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.in_set, r_out.count, r_out.row, r_out.column};

endmodule

// File: dv/mandelbrot_escape_time_core_tb.sv
`timescale 1ns / 100ps

module mandelbrot_escape_time_core_tb;
    import mbet_pkg::*;

    localparam int RANDOM_PIXELS = 1200;
    localparam int CALM_TAIL     = 150;
    localparam int HOLD_CYCLES   = 3000;
    localparam int STALL_LIMIT   = 1000000;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

    class escape_tracker;
        logic signed [31:0] origin_re;
        logic signed [31:0] origin_im;
        logic [24:0]        step_re;
        logic [24:0]        step_im;
        logic [30:0]        radius_sq;
        logic [CNT_W-1:0]   iter_limit;
        t_result            pending_escapes[$];
        int                 mismatches;

        function new();
            origin_re  = RST_REAL_ORIGIN;
            origin_im  = RST_IMAG_ORIGIN;
            step_re    = RST_STEP;
            step_im    = RST_STEP;
            radius_sq  = RST_ESCAPE_RSQ;
            iter_limit = RST_MAX_ITER;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_REAL_ORIGIN: origin_re  = data;
                CFG_IMAG_ORIGIN: origin_im  = data;
                CFG_STEP_REAL:   step_re    = data[24:0];
                CFG_STEP_IMAG:   step_im    = data[24:0];
                CFG_ESCAPE_RSQ:  radius_sq  = data[30:0];
                CFG_MAX_ITER:    iter_limit = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_q(longint v);
            longint r;
            r = v;
            if (v > Q_MAX) r = Q_MAX;
            if (v < Q_MIN) r = Q_MIN;
            return r;
        endfunction

        function t_result escape_count_for(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
            longint      c_re;
            longint      c_im;
            longint      x;
            longint      y;
            longint      xx;
            longint      yy;
            longint      xy;
            int unsigned n;
            int unsigned rounds;
            bit          escaped;
            t_result     r;
            c_re    = clamp_q(longint'(origin_re) + longint'(col) * longint'(step_re));
            c_im    = clamp_q(longint'(origin_im) + longint'(row) * longint'(step_im));
            x       = c_re;
            y       = c_im;
            rounds  = 0;
            escaped = 1'b0;
            n       = 0;
            while (!escaped && n < iter_limit) begin
                xx = (x * x) >>> FRAC_BITS;
                yy = (y * y) >>> FRAC_BITS;
                xy = (x * y) >>> FRAC_BITS;
                if (xx + yy > longint'(radius_sq)) begin
                    escaped = 1'b1;
                end else begin
                    rounds++;
                    x = clamp_q(xx - yy + c_re);
                    y = clamp_q(2 * xy + c_im);
                end
                n++;
            end
            r.column = col;
            r.row    = row;
            r.count  = rounds[CNT_W-1:0];
            r.in_set = (rounds >= iter_limit);
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
            pending_escapes.push_back(escape_count_for(col, row));
        endfunction

        function int outstanding();
            return pending_escapes.size();
        endfunction

        task report(string what, int got, int want);
            $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_escapes.size() == 0) begin
                report("result with no pixel pending, column", got.column, -1);
            end else begin
                want = pending_escapes.pop_front();
                if (got.column != want.column) report("column", got.column, want.column);
                if (got.row != want.row) report("row", got.row, want.row);
                if (got.count != want.count) report("iteration count", got.count, want.count);
                if (got.in_set != want.in_set) report("in-set flag", got.in_set, want.in_set);
            end
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data = '0;

    escape_tracker board = new();
    bit            idling_on = 1'b1;
    bit            hold_req  = 1'b0;
    int            stall_cycles = 0;

    mandelbrot_escape_time_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_result got;
        got.column = m_axis_tdata[9:0];
        got.row    = m_axis_tdata[19:10];
        got.count  = m_axis_tdata[35:20];
        got.in_set = m_axis_tdata[36];
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            board.note_pixel(s_axis_tdata[9:0], s_axis_tdata[19:10]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(got);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: long hold-off on request, otherwise short random backpressure
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold_req = 1'b0;
            m_axis_tready <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic program_all(input logic [31:0] re_w, input logic [31:0] im_w,
                               input logic [31:0] sr_w, input logic [31:0] si_w,
                               input logic [31:0] rsq_w, input logic [31:0] lim_w);
        write_reg(CFG_REAL_ORIGIN, re_w);
        write_reg(CFG_IMAG_ORIGIN, im_w);
        write_reg(CFG_STEP_REAL, sr_w);
        write_reg(CFG_STEP_IMAG, si_w);
        write_reg(CFG_ESCAPE_RSQ, rsq_w);
        write_reg(CFG_MAX_ITER, lim_w);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, row, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // drop valid and hold until every pending pixel has come back
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    initial begin
        int          sent;
        int          batch;
        int          batch_no;
        bit          heavy;
        logic [31:0] re_w;
        logic [31:0] im_w;
        logic [31:0] sr_w;
        logic [31:0] si_w;
        logic [31:0] rsq_w;
        logic [31:0] lim_w;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default view: corners, alternating bits, points inside the set
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd512, 10'd683);
        settle();

        // zero iteration limit
        program_all(32'h0, 32'h0, 32'd49152, 32'd49152, 32'h0400_0000, 32'h0);
        send_pixel(10'd5, 10'd7);
        send_pixel(10'd1023, 10'd1023);
        settle();

        // saturating point, widest steps, full radius with upper bits masked
        program_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h01FF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_0001);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1, 10'd1);
        settle();

        program_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd300, 10'd300);
        settle();

        // origin pinned at zero: full count at the largest limit
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        program_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
        send_pixel(10'd1023, 10'd1023);
        settle();

        sent     = 0;
        batch_no = 0;
        while (sent < RANDOM_PIXELS) begin
            heavy = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) != 0) begin
                re_w = $urandom_range(0, 32'd50331648) - 32'd41943040;
                im_w = $urandom_range(0, 32'd33554432) - 32'd25165824;
                sr_w = {7'($urandom_range(0, 127)),
                        25'($urandom_range(0, 98304) >> $urandom_range(0, 8))};
                si_w = {7'($urandom_range(0, 127)),
                        25'($urandom_range(0, 98304) >> $urandom_range(0, 8))};
                case ($urandom_range(0, 3))
                    0:       rsq_w = {1'($urandom), 31'h0400_0000};
                    1:       rsq_w = {1'($urandom), RST_ESCAPE_RSQ};
                    2:       rsq_w = $urandom;
                    default: rsq_w = $urandom_range(0, 32'h1000_0000);
                endcase
            end else begin
                re_w  = $urandom;
                im_w  = $urandom;
                sr_w  = $urandom;
                si_w  = $urandom;
                rsq_w = $urandom;
            end
            lim_w = {16'($urandom),
                     heavy ? 16'($urandom_range(100, 256)) : 16'($urandom_range(1, 40))};
            program_all(re_w, im_w, sr_w, si_w, rsq_w, lim_w);

            batch = heavy ? $urandom_range(5, 20) : $urandom_range(20, 80);
            if (batch_no == 2 && batch < 12) batch = 12;
            if (sent + batch > RANDOM_PIXELS) batch = RANDOM_PIXELS - sent;
            idling_on = (sent < RANDOM_PIXELS - CALM_TAIL);
            if (batch_no == 2) hold_req = 1'b1;
            repeat (batch) begin
                send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
                sent++;
            end
            settle();
            batch_no++;
        end

        repeat (4 * (int'(board.iter_limit) + 2) + 16) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mbet_pkg.sv
rtl/core/mbet_mul.sv
rtl/core/mbet_seq.sv
rtl/core/mandelbrot_escape_time_core.sv
dv/mandelbrot_escape_time_core_tb.sv
